>>> src/lsrt_pkg.sv
// Shared types, constants and helpers for the lease slot reservation table.
package lsrt_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_BITS = 4;
  localparam int PTR_BITS  = 5;
  localparam int TIME_BITS = 32;
  localparam int TAG_BITS  = 8;
  localparam int CNT_BITS  = 5;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [CNT_BITS-1:0] ACT_MAX = '1;

  typedef enum logic [2:0] {
    F_RESERVE        = 3'd0,
    F_CLAIM          = 3'd1,
    F_COMMIT         = 3'd2,
    F_RELEASE        = 3'd3,
    F_RELEASE_ACTIVE = 3'd4,
    F_EXPIRE         = 3'd5,
    F_QUERY          = 3'd6,
    F_LIST           = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    E_FREE    = 2'd0,
    E_PENDING = 2'd1,
    E_CLAIMED = 2'd2
  } ent_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXPIRE,
    S_EXEC,
    S_LIST
  } fsm_t;

  typedef enum logic [1:0] {
    R_MAX_PLAYERS = 2'd0,
    R_PENDING_LIFE = 2'd1,
    R_CLAIMED_LIFE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]  max_players;
    logic [TIME_BITS-1:0] pending_life;
    logic [TIME_BITS-1:0] claimed_life;
  } cfg_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 expire_en;
    logic                 reserve_en;
    logic                 claim_en;
    logic                 commit_en;
    logic                 release_en;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] pend_end;
    logic [TIME_BITS-1:0] claim_end;
    logic [SLOT_BITS-1:0] tok_slot;
    logic [TAG_BITS-1:0]  tok_tag;
    logic [PTR_BITS-1:0]  list_ptr;
  } cell_cmd_t;

  // Handed from each cell to the next higher slot.
  typedef struct packed {
    logic                 free_found;
    logic [SLOT_BITS-1:0] res_slot;
    logic [TAG_BITS-1:0]  res_tag;
    logic                 tok_pending;
    logic                 tok_claimed;
    logic                 tok_occ;
    logic [1:0]           list_cnt;
    logic [SLOT_BITS-1:0] list_slot;
    logic [TAG_BITS-1:0]  list_tag;
  } cell_link_t;

  // Lease end: zero lifetime counts as one tick, and the sum saturates.
  function automatic logic [TIME_BITS-1:0] lease_end(input logic [TIME_BITS-1:0] now,
                                                     input logic [TIME_BITS-1:0] life);
    logic [TIME_BITS-1:0] life1;
    logic [TIME_BITS:0]   sum;
    life1 = (life == '0) ? TIME_BITS'(1) : life;
    sum   = {1'b0, now} + {1'b0, life1};
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

endpackage

>>> src/lsrt_cell.sv
// One table slot: state, lease expiry and generation tag, chained to its neighbor.
module lsrt_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lsrt_pkg::SLOT_BITS-1:0]  idx,
  input  lsrt_pkg::cell_cmd_t             cmd,
  input  lsrt_pkg::cell_link_t            link_in,
  output lsrt_pkg::cell_link_t            link_out,
  output logic                            occ
);

  lsrt_pkg::ent_t                       st;
  lsrt_pkg::ent_t                       st_next;
  logic [lsrt_pkg::TIME_BITS-1:0]       expiry;
  logic [lsrt_pkg::TIME_BITS-1:0]       expiry_next;
  logic [lsrt_pkg::TAG_BITS-1:0]        tag;
  logic [lsrt_pkg::TAG_BITS-1:0]        tag_next;
  logic                                 free;
  logic                                 match;
  logic                                 take;
  logic                                 eligible;

  assign free     = (st == lsrt_pkg::E_FREE);
  assign match    = (cmd.tok_slot == idx) && !free && (tag == cmd.tok_tag);
  assign take     = cmd.reserve_en && free && !link_in.free_found;
  assign eligible = (st == lsrt_pkg::E_CLAIMED) && ({1'b0, idx} >= cmd.list_ptr);
  assign occ      = !free;

  // Chain outputs: lowest free slot, token checks, and the list scan.
  always_comb begin
    link_out            = link_in;
    link_out.free_found = link_in.free_found | free;
    if (!link_in.free_found && free) begin
      link_out.res_slot = idx;
      link_out.res_tag  = tag + 1'b1;
    end
    link_out.tok_pending = link_in.tok_pending | (match && st == lsrt_pkg::E_PENDING);
    link_out.tok_claimed = link_in.tok_claimed | (match && st == lsrt_pkg::E_CLAIMED);
    link_out.tok_occ     = link_in.tok_occ | match;
    if (eligible) begin
      if (link_in.list_cnt == 2'd0) begin
        link_out.list_slot = idx;
        link_out.list_tag  = tag;
      end
      link_out.list_cnt = (link_in.list_cnt == 2'd2) ? 2'd2 : link_in.list_cnt + 2'd1;
    end
  end

  always_comb begin
    st_next     = st;
    expiry_next = expiry;
    tag_next    = tag;
    priority if (cmd.expire_en && !free && expiry <= cmd.now) begin
      st_next = lsrt_pkg::E_FREE;
    end else if (take) begin
      st_next     = lsrt_pkg::E_PENDING;
      tag_next    = tag + 1'b1;
      expiry_next = cmd.pend_end;
    end else if (cmd.claim_en && match && st == lsrt_pkg::E_PENDING) begin
      st_next     = lsrt_pkg::E_CLAIMED;
      expiry_next = cmd.claim_end;
    end else if (cmd.commit_en && match && st == lsrt_pkg::E_CLAIMED) begin
      st_next = lsrt_pkg::E_FREE;
    end else if (cmd.release_en && match) begin
      st_next = lsrt_pkg::E_FREE;
    end else begin
      st_next = st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= lsrt_pkg::E_FREE;
      tag <= '0;
    end else begin
      st  <= st_next;
      tag <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    expiry <= expiry_next;
  end

endmodule

>>> src/lsrt_cfg.sv
// Register file for the table's configuration, written over the APB-style port.
module lsrt_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsrt_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lsrt_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lsrt_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  output lsrt_pkg::cfg_t                  cfg
);

  lsrt_pkg::reg_idx_t ridx;
  logic               wr;

  assign ridx   = lsrt_pkg::reg_idx_t'(paddr[lsrt_pkg::ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_players  <= lsrt_pkg::CNT_BITS'(16);
      cfg.pending_life <= lsrt_pkg::TIME_BITS'(1000);
      cfg.claimed_life <= lsrt_pkg::TIME_BITS'(1000);
    end else if (wr) begin
      unique case (ridx)
        lsrt_pkg::R_MAX_PLAYERS:  cfg.max_players  <= pwdata[lsrt_pkg::CNT_BITS-1:0];
        lsrt_pkg::R_PENDING_LIFE: cfg.pending_life <= pwdata[lsrt_pkg::TIME_BITS-1:0];
        lsrt_pkg::R_CLAIMED_LIFE: cfg.claimed_life <= pwdata[lsrt_pkg::TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      lsrt_pkg::R_MAX_PLAYERS:
        prdata = lsrt_pkg::DATA_BITS'(cfg.max_players);
      lsrt_pkg::R_PENDING_LIFE: prdata = cfg.pending_life;
      lsrt_pkg::R_CLAIMED_LIFE: prdata = cfg.claimed_life;
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> src/lease_slot_reservation_table.sv
// Top level of the lease slot reservation table: sequencer, cell chain and result register.
//
//  Channel   Direction  Handshake              Payload
//  req       in         req_valid / req_stall  func, now_tick, token_slot, token_tag
//  rsp       out        rsp_valid / rsp_stall  ok, out_slot, out_tag, active_total,
//                                              reserved_total, last
//  cfg       in         psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// A single-result request passes through the accepting step, an expiry step in which every
// cell checks its lease against now_tick for reserve, claim, expire and query requests, and
// an execute step in which the chain finds the lowest free slot and checks the token.
// A list_claimed request instead takes a list step per result, with at least one result.
// Reset is synchronous: slots free, tags and active count zero, registers at defaults.
// A stalled result holds the execute or list step until the output register drains.
module lease_slot_reservation_table (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [2:0]                      func,
  input  logic [lsrt_pkg::TIME_BITS-1:0]  now_tick,
  input  logic [lsrt_pkg::SLOT_BITS-1:0]  token_slot,
  input  logic [lsrt_pkg::TAG_BITS-1:0]   token_tag,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            ok,
  output logic [lsrt_pkg::SLOT_BITS-1:0]  out_slot,
  output logic [lsrt_pkg::TAG_BITS-1:0]   out_tag,
  output logic [lsrt_pkg::CNT_BITS-1:0]   active_total,
  output logic [lsrt_pkg::CNT_BITS-1:0]   reserved_total,
  output logic                            last,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsrt_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lsrt_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lsrt_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);

  lsrt_pkg::cfg_t                    cfg;
  lsrt_pkg::fsm_t                    state;
  lsrt_pkg::fsm_t                    state_next;
  lsrt_pkg::func_t                   func_q;
  logic [lsrt_pkg::TIME_BITS-1:0]    now_q;
  logic [lsrt_pkg::SLOT_BITS-1:0]    slot_q;
  logic [lsrt_pkg::TAG_BITS-1:0]     tag_q;
  logic [lsrt_pkg::PTR_BITS-1:0]     list_ptr;
  logic [lsrt_pkg::PTR_BITS-1:0]     list_ptr_next;
  logic [lsrt_pkg::CNT_BITS-1:0]     active_count;
  logic [lsrt_pkg::CNT_BITS-1:0]     active_next;

  lsrt_pkg::cell_cmd_t               cmd;
  lsrt_pkg::cell_link_t              links [lsrt_pkg::SLOTS+1];
  lsrt_pkg::cell_link_t              tail;
  logic [lsrt_pkg::SLOTS-1:0]        occ_vec;
  logic [lsrt_pkg::CNT_BITS-1:0]     occ_cnt;
  logic [lsrt_pkg::CNT_BITS-1:0]     cap;
  logic                              cap_ok;
  logic                              out_free;
  logic                              do_exec;
  logic                              accept;
  logic                              expiring_op;

  logic                              load;
  logic                              ok_next;
  logic [lsrt_pkg::SLOT_BITS-1:0]    slot_next;
  logic [lsrt_pkg::TAG_BITS-1:0]     tag_next;
  logic [lsrt_pkg::CNT_BITS-1:0]     res_next;
  logic                              last_next;

  lsrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign req_stall = (state != lsrt_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign do_exec   = (state == lsrt_pkg::S_EXEC) && out_free;

  // Reserve, claim, expire and count queries free stale leases first.
  assign expiring_op = (func_q == lsrt_pkg::F_RESERVE) || (func_q == lsrt_pkg::F_CLAIM) ||
                       (func_q == lsrt_pkg::F_EXPIRE)  || (func_q == lsrt_pkg::F_QUERY);

  always_comb begin
    cmd            = '0;
    cmd.expire_en  = (state == lsrt_pkg::S_EXPIRE) && expiring_op;
    cmd.reserve_en = do_exec && (func_q == lsrt_pkg::F_RESERVE) && cap_ok;
    cmd.claim_en   = do_exec && (func_q == lsrt_pkg::F_CLAIM);
    cmd.commit_en  = do_exec && (func_q == lsrt_pkg::F_COMMIT);
    cmd.release_en = do_exec && (func_q == lsrt_pkg::F_RELEASE);
    cmd.now        = now_q;
    cmd.pend_end   = lsrt_pkg::lease_end(now_q, cfg.pending_life);
    cmd.claim_end  = lsrt_pkg::lease_end(now_q, cfg.claimed_life);
    cmd.tok_slot   = slot_q;
    cmd.tok_tag    = tag_q;
    cmd.list_ptr   = list_ptr;
  end

  // The chain runs from slot zero upward; the head sees nothing found yet.
  assign links[0] = '0;

  for (genvar i = 0; i < lsrt_pkg::SLOTS; i++) begin : g_cell
    lsrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (lsrt_pkg::SLOT_BITS'(i)),
      .cmd      (cmd),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .occ      (occ_vec[i])
    );
  end

  assign tail    = links[lsrt_pkg::SLOTS];
  assign occ_cnt = lsrt_pkg::CNT_BITS'($countones(occ_vec));

  // A capacity of zero behaves as a capacity of one.
  assign cap    = (cfg.max_players == '0) ? lsrt_pkg::CNT_BITS'(1) : cfg.max_players;
  assign cap_ok = ({1'b0, active_count} + {1'b0, occ_cnt}) < {1'b0, cap};

  always_comb begin
    state_next    = state;
    load          = 1'b0;
    ok_next       = 1'b0;
    slot_next     = '0;
    tag_next      = '0;
    res_next      = occ_cnt;
    last_next     = 1'b1;
    active_next   = active_count;
    list_ptr_next = list_ptr;
    unique case (state)
      lsrt_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = lsrt_pkg::S_EXPIRE;
        end
      end
      lsrt_pkg::S_EXPIRE: begin
        state_next = (func_q == lsrt_pkg::F_LIST) ? lsrt_pkg::S_LIST : lsrt_pkg::S_EXEC;
      end
      lsrt_pkg::S_EXEC: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = lsrt_pkg::S_IDLE;
          unique case (func_q)
            lsrt_pkg::F_RESERVE: begin
              if (cap_ok && tail.free_found) begin
                ok_next   = 1'b1;
                slot_next = tail.res_slot;
                tag_next  = tail.res_tag;
                res_next  = occ_cnt + 1'b1;
              end
            end
            lsrt_pkg::F_CLAIM: begin
              ok_next = tail.tok_pending;
            end
            lsrt_pkg::F_COMMIT: begin
              if (tail.tok_claimed) begin
                ok_next  = 1'b1;
                res_next = occ_cnt - 1'b1;
                if (active_count != lsrt_pkg::ACT_MAX) begin
                  active_next = active_count + 1'b1;
                end
              end
            end
            lsrt_pkg::F_RELEASE: begin
              if (tail.tok_occ) begin
                ok_next  = 1'b1;
                res_next = occ_cnt - 1'b1;
              end
            end
            lsrt_pkg::F_RELEASE_ACTIVE: begin
              if (active_count != '0) begin
                ok_next     = 1'b1;
                active_next = active_count - 1'b1;
              end
            end
            lsrt_pkg::F_EXPIRE, lsrt_pkg::F_QUERY: begin
              ok_next = 1'b1;
            end
            lsrt_pkg::F_LIST: begin
              ok_next = 1'b0;
            end
          endcase
        end
      end
      lsrt_pkg::S_LIST: begin
        if (out_free) begin
          load = 1'b1;
          if (tail.list_cnt == 2'd0) begin
            // Nothing claimed: one empty result closes the run.
            state_next = lsrt_pkg::S_IDLE;
          end else begin
            ok_next       = 1'b1;
            slot_next     = tail.list_slot;
            tag_next      = tail.list_tag;
            last_next     = (tail.list_cnt == 2'd1);
            list_ptr_next = {1'b0, tail.list_slot} + 1'b1;
            if (tail.list_cnt == 2'd1) begin
              state_next = lsrt_pkg::S_IDLE;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lsrt_pkg::S_IDLE;
      active_count <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      active_count <= active_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= lsrt_pkg::func_t'(func);
      now_q    <= now_tick;
      slot_q   <= token_slot;
      tag_q    <= token_tag;
      list_ptr <= '0;
    end else begin
      list_ptr <= list_ptr_next;
    end
    if (load) begin
      ok             <= ok_next;
      out_slot       <= slot_next;
      out_tag        <= tag_next;
      active_total   <= active_next;
      reserved_total <= res_next;
      last           <= last_next;
    end
  end

  a_accept_starts_expiry: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == lsrt_pkg::S_EXPIRE)
    else $error("accepted item did not enter the expiry step");

  a_list_state_func: assert property (@(posedge clk) disable iff (rst)
    state == lsrt_pkg::S_LIST |-> func_q == lsrt_pkg::F_LIST)
    else $error("list scan running for a non-list request");

  a_reserve_counts: assert property (@(posedge clk) disable iff (rst)
    (do_exec && func_q == lsrt_pkg::F_RESERVE && cap_ok && tail.free_found)
      |=> rsp_valid && ok && reserved_total != '0)
    else $error("granted reserve reported no occupied slot");

  a_commit_active: assert property (@(posedge clk) disable iff (rst)
    (do_exec && func_q == lsrt_pkg::F_COMMIT && tail.tok_claimed &&
     active_count != lsrt_pkg::ACT_MAX)
      |=> active_total == $past(active_count) + 1'b1)
    else $error("commit did not raise the active count");

  a_list_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == lsrt_pkg::S_LIST && out_free && tail.list_cnt != 2'd2)
      |=> state == lsrt_pkg::S_IDLE && rsp_valid && last)
    else $error("final list transfer did not end the run");

endmodule

>>> tb/lease_table_monitor.sv
// Result checker for the lease slot reservation table: tracks the table and compares results.
`timescale 1ns / 1ps
module lease_table_monitor
  import lsrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  logic [2:0]           func,
  input  logic [TIME_BITS-1:0] now_tick,
  input  logic [SLOT_BITS-1:0] token_slot,
  input  logic [TAG_BITS-1:0]  token_tag,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  logic                 ok,
  input  logic [SLOT_BITS-1:0] out_slot,
  input  logic [TAG_BITS-1:0]  out_tag,
  input  logic [CNT_BITS-1:0]  active_total,
  input  logic [CNT_BITS-1:0]  reserved_total,
  input  logic                 last,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  input  logic                 drain_done,
  output int                   mismatches
);

  typedef struct packed {
    logic                 ok;
    logic [SLOT_BITS-1:0] slot;
    logic [TAG_BITS-1:0]  tag;
    logic [CNT_BITS-1:0]  active;
    logic [CNT_BITS-1:0]  held;
    logic                 last;
  } lease_result_t;

  ent_t                 slot_state  [SLOTS];
  logic [TIME_BITS-1:0] slot_expiry [SLOTS];
  logic [TAG_BITS-1:0]  slot_tag    [SLOTS];
  logic [CNT_BITS-1:0]  active_cnt;
  logic [CNT_BITS-1:0]  cap_reg;
  logic [TIME_BITS-1:0] pend_life;
  logic [TIME_BITS-1:0] claim_life;
  lease_result_t        due_results [$];
  int                   results_seen;
  bit                   leftover_flagged;

  initial begin
    mismatches       = 0;
    results_seen     = 0;
    leftover_flagged = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 40)
      $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  function automatic logic [CNT_BITS-1:0] held_slots();
    logic [CNT_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] != E_FREE) n++;
    return n;
  endfunction

  // A zero lease counts as one tick; the end saturates at the largest tick.
  function automatic logic [TIME_BITS-1:0] lease_deadline(input logic [TIME_BITS-1:0] t,
                                                          input logic [TIME_BITS-1:0] life);
    logic [TIME_BITS-1:0] span;
    span = (life == '0) ? TIME_BITS'(1) : life;
    if (span > ~t) return '1;
    return t + span;
  endfunction

  function automatic bit token_held(input logic [SLOT_BITS-1:0] s,
                                    input logic [TAG_BITS-1:0] g);
    return slot_state[s] != E_FREE && slot_tag[s] == g;
  endfunction

  task automatic drop_expired(input logic [TIME_BITS-1:0] t);
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] != E_FREE && slot_expiry[i] <= t) slot_state[i] = E_FREE;
  endtask

  task automatic push_result(input logic good, input logic [SLOT_BITS-1:0] s,
                             input logic [TAG_BITS-1:0] g, input logic fin);
    lease_result_t r;
    r.ok     = good;
    r.slot   = s;
    r.tag    = g;
    r.active = active_cnt;
    r.held   = held_slots();
    r.last   = fin;
    due_results.push_back(r);
  endtask

  task automatic apply_lease_request(input func_t f, input logic [TIME_BITS-1:0] t,
                                     input logic [SLOT_BITS-1:0] s,
                                     input logic [TAG_BITS-1:0] g);
    int cap;
    int n_claimed;
    int k;
    bit granted;
    cap     = (cap_reg == '0) ? 1 : int'(cap_reg);
    granted = 1'b0;
    case (f)
      F_RESERVE: begin
        drop_expired(t);
        if (int'(active_cnt) + int'(held_slots()) < cap) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!granted && slot_state[i] == E_FREE) begin
              slot_state[i]  = E_PENDING;
              slot_tag[i]    = slot_tag[i] + 1'b1;
              slot_expiry[i] = lease_deadline(t, pend_life);
              push_result(1'b1, SLOT_BITS'(i), slot_tag[i], 1'b1);
              granted = 1'b1;
            end
          end
        end
        if (!granted) push_result(1'b0, '0, '0, 1'b1);
      end
      F_CLAIM: begin
        drop_expired(t);
        if (token_held(s, g) && slot_state[s] == E_PENDING) begin
          slot_state[s]  = E_CLAIMED;
          slot_expiry[s] = lease_deadline(t, claim_life);
          push_result(1'b1, '0, '0, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, 1'b1);
        end
      end
      F_COMMIT: begin
        if (token_held(s, g) && slot_state[s] == E_CLAIMED) begin
          slot_state[s] = E_FREE;
          if (active_cnt != '1) active_cnt++;
          push_result(1'b1, '0, '0, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, 1'b1);
        end
      end
      F_RELEASE: begin
        if (token_held(s, g)) begin
          slot_state[s] = E_FREE;
          push_result(1'b1, '0, '0, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, 1'b1);
        end
      end
      F_RELEASE_ACTIVE: begin
        if (active_cnt != '0) begin
          active_cnt--;
          push_result(1'b1, '0, '0, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, 1'b1);
        end
      end
      F_EXPIRE, F_QUERY: begin
        drop_expired(t);
        push_result(1'b1, '0, '0, 1'b1);
      end
      default: begin
        n_claimed = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_state[i] == E_CLAIMED) n_claimed++;
        if (n_claimed == 0) begin
          push_result(1'b0, '0, '0, 1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_state[i] == E_CLAIMED) begin
              k++;
              push_result(1'b1, SLOT_BITS'(i), slot_tag[i], k == n_claimed);
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    lease_result_t seen;
    lease_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i]  = E_FREE;
        slot_expiry[i] = '0;
        slot_tag[i]    = '0;
      end
      active_cnt = '0;
      cap_reg    = CNT_BITS'(16);
      pend_life  = TIME_BITS'(1000);
      claim_life = TIME_BITS'(1000);
      due_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        seen = {ok, out_slot, out_tag, active_total, reserved_total, last};
        if (due_results.size() == 0) begin
          report_mismatch("result arrived with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("ok", seen.ok, want.ok);
          check_field("out_slot", seen.slot, want.slot);
          check_field("out_tag", seen.tag, want.tag);
          check_field("active_total", seen.active, want.active);
          check_field("reserved_total", seen.held, want.held);
          check_field("last", seen.last, want.last);
        end
        results_seen++;
      end
      if (req_valid && !req_stall)
        apply_lease_request(func_t'(func), now_tick, token_slot, token_tag);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          R_MAX_PLAYERS:  cap_reg    = pwdata[CNT_BITS-1:0];
          R_PENDING_LIFE: pend_life  = pwdata[TIME_BITS-1:0];
          R_CLAIMED_LIFE: claim_life = pwdata[TIME_BITS-1:0];
          default: ;
        endcase
      end
      if (drain_done && !leftover_flagged && due_results.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never arrived",
                                  due_results.size()));
        leftover_flagged = 1'b1;
      end
    end
  end

endmodule

>>> tb/tb_lease_slot_reservation_table.sv
// Testbench top for the lease slot reservation table: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_lease_slot_reservation_table;
  import lsrt_pkg::*;

  // The watchdog sits far above the slowest legal run: every request listing all
  // sixteen slots, each result waiting out a long run of stalls.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the deliberate result hold-off in the pressure phase.
  localparam int HOLD_CYCLES = 80;

  logic                 clk;
  logic                 rst            = 1'b1;
  logic                 req_valid      = 1'b0;
  logic                 req_stall;
  logic [2:0]           func           = '0;
  logic [TIME_BITS-1:0] now_tick       = '0;
  logic [SLOT_BITS-1:0] token_slot     = '0;
  logic [TAG_BITS-1:0]  token_tag      = '0;
  logic                 rsp_valid;
  logic                 rsp_stall      = 1'b0;
  logic                 ok;
  logic [SLOT_BITS-1:0] out_slot;
  logic [TAG_BITS-1:0]  out_tag;
  logic [CNT_BITS-1:0]  active_total;
  logic [CNT_BITS-1:0]  reserved_total;
  logic                 last;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [ADDR_BITS-1:0] paddr          = '0;
  logic [DATA_BITS-1:0] pwdata         = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 drain_done     = 1'b0;
  int                   mismatches;

  // Stimulus bookkeeping. Requests sent are matched against results flagged as
  // last, since every request ends in exactly one such result.
  int                   sent_cnt       = 0;
  int                   runs_done      = 0;
  int                   result_cnt     = 0;
  int                   cycle_count    = 0;
  int                   idle_pct       = 0;
  int                   stall_pct      = 0;
  int                   op_seen [8]    = '{default: 0};
  logic                 hold_req       = 1'b0;
  logic                 hold_on        = 1'b0;
  logic [TIME_BITS-1:0] now_cur        = '0;
  // Latest token handed out per slot, learned from the result channel so that
  // claims, commits and releases mostly carry live tokens.
  logic [TAG_BITS-1:0]  learned_tag [SLOTS] = '{default: '0};

  lease_slot_reservation_table u_dut (.*);

  lease_table_monitor u_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls at the phase's rate, or solidly while the pressure
  // hold-off is running.
  always @(posedge clk)
    rsp_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);

  // Pressure: once requested, the result side holds off for a fixed stretch while
  // the request side keeps offering transfers, so the block backs up and stalls.
  initial begin : result_hold
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_cnt <= result_cnt + 1;
      if (last) runs_done <= runs_done + 1;
      // Claim and release results carry slot zero and tag zero; skip those.
      if (ok && (out_slot != '0 || out_tag != '0)) learned_tag[out_slot] <= out_tag;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Offers one request transfer, with an optional idle gap in front of it, and
  // returns at the edge where the block takes it.
  task automatic send_request(input func_t f, input logic [TIME_BITS-1:0] t,
                              input logic [SLOT_BITS-1:0] s,
                              input logic [TAG_BITS-1:0] g);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    func       <= f;
    now_tick   <= t;
    token_slot <= s;
    token_tag  <= g;
    req_valid  <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_cnt++;
    op_seen[f]++;
  endtask

  // Waits until every request so far has delivered its final result.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (runs_done != sent_cnt) @(posedge clk);
  endtask

  // One register write: setup phase, then access phase.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Builds one random request. Most requests follow the reserve, claim, commit
  // flow on tokens that were handed out; about one in ten is pure noise.
  task automatic random_request(input int step, input int res_pct);
    int                   pick;
    int                   hi_slot;
    func_t                f;
    logic [SLOT_BITS-1:0] s;
    logic [TAG_BITS-1:0]  g;
    logic [TIME_BITS-1:0] inc;
    hi_slot = 0;
    for (int i = 0; i < SLOTS; i++)
      if (learned_tag[i] != '0) hi_slot = i;
    pick = $urandom_range(0, 99);
    if (pick < res_pct) begin
      f = F_RESERVE;
    end else begin
      pick = $urandom_range(0, 71);
      if (pick < 20)      f = F_CLAIM;
      else if (pick < 34) f = F_COMMIT;
      else if (pick < 42) f = F_RELEASE;
      else if (pick < 49) f = F_RELEASE_ACTIVE;
      else if (pick < 55) f = F_EXPIRE;
      else if (pick < 61) f = F_QUERY;
      else                f = F_LIST;
    end
    s = SLOT_BITS'($urandom_range(0, hi_slot));
    g = ($urandom_range(0, 99) < 85) ? learned_tag[s] : TAG_BITS'($urandom);
    if ($urandom_range(0, 99) < 10) begin
      f = func_t'($urandom_range(0, 7));
      s = SLOT_BITS'($urandom);
      g = TAG_BITS'($urandom);
    end
    // The tick only moves forward and sticks at its largest value.
    inc     = TIME_BITS'($urandom_range(0, step));
    now_cur = (inc > ~now_cur) ? '1 : now_cur + inc;
    send_request(f, now_cur, s, g);
  endtask

  // A phase: new register values while the block is idle, a new idling pattern,
  // a jump of the tick, then a run of random requests.
  task automatic run_phase(input logic [CNT_BITS-1:0] cap, input logic [31:0] pend,
                           input logic [31:0] claim, input int mode, input int n,
                           input int step, input int res_pct,
                           input logic [TIME_BITS-1:0] jump);
    write_reg(R_MAX_PLAYERS, DATA_BITS'(cap));
    write_reg(R_PENDING_LIFE, pend);
    write_reg(R_CLAIMED_LIFE, claim);
    idle_pct   = (mode == 1) ? 68 : (mode == 3) ? 36 : 0;
    stall_pct <= (mode == 2) ? 68 : (mode == 3) ? 36 : 0;
    now_cur    = (jump > ~now_cur) ? '1 : now_cur + jump;
    repeat (n) random_request(step, res_pct);
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: capacity 16, both leases 1000 ticks.
    send_request(F_LIST, 32'd0, 4'd0, 8'd0);              // empty list
    send_request(F_RELEASE_ACTIVE, 32'd0, 4'd0, 8'd0);    // nothing active yet
    send_request(F_CLAIM, 32'd0, 4'd15, 8'hFF);           // token of a free slot
    send_request(F_COMMIT, 32'd0, 4'd0, 8'd0);
    send_request(F_RESERVE, 32'd10, 4'd0, 8'd0);          // slot 0, tag 1
    send_request(F_CLAIM, 32'd11, 4'd0, 8'd2);            // stale tag
    send_request(F_COMMIT, 32'd11, 4'd0, 8'd1);           // still pending
    send_request(F_CLAIM, 32'd12, 4'd0, 8'd1);
    send_request(F_CLAIM, 32'd13, 4'd0, 8'd1);            // already claimed
    send_request(F_RESERVE, 32'd14, 4'd0, 8'd0);          // slot 1, tag 1
    send_request(F_LIST, 32'd14, 4'd0, 8'd0);
    send_request(F_COMMIT, 32'd15, 4'd0, 8'd1);
    send_request(F_RELEASE, 32'd15, 4'd1, 8'd1);
    send_request(F_RELEASE, 32'd15, 4'd1, 8'd1);          // slot already free
    send_request(F_RELEASE_ACTIVE, 32'd16, 4'd0, 8'd0);
    send_request(F_RESERVE, 32'd20, 4'd0, 8'd0);          // slot 0, tag 2, ends 1020
    send_request(F_RESERVE, 32'd20, 4'd0, 8'd0);          // slot 1, tag 2
    send_request(F_CLAIM, 32'd21, 4'd1, 8'd2);            // ends 1021
    send_request(F_QUERY, 32'd500, 4'd0, 8'd0);
    send_request(F_LIST, 32'd500, 4'd0, 8'd0);
    send_request(F_EXPIRE, 32'd1020, 4'd0, 8'd0);         // lease ends exactly now
    send_request(F_QUERY, 32'd1021, 4'd0, 8'd0);
    send_request(F_LIST, 32'd1021, 4'd0, 8'd0);           // empty again
    now_cur = 32'd1021;
    wait_drained();

    // Random phases: tight capacity with short leases, a capacity of one with
    // leases that round up and never end, the widest capacity so that no slot is
    // left, a zero capacity, the pressure phase, and finally the top of the tick
    // range with saturating leases.
    run_phase(5'd4,  32'd40, 32'd80, 0, 48, 6, 28, 32'd0);
    run_phase(5'd1,  32'd0, 32'hFFFF_FFFF, 1, 48, 2, 28, 32'd100);
    run_phase(5'd31, 32'd500, 32'd500, 2, 48, 3, 60, 32'd100);
    run_phase(5'd0,  32'd0, 32'd0, 3, 48, 1, 28, 32'd2000);
    hold_req = 1'b1;
    run_phase(5'd16, 32'd60, 32'd120, 0, 48, 6, 35, 32'd2000);
    run_phase(5'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 48, 4, 35,
              32'hFFFF_FF80 - now_cur);

    // Let the block settle, then have the checker look for stragglers.
    repeat (8) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d requests and %0d result transfers over seven settings,",
             sent_cnt, result_cnt);
    $display("  ops rsv %0d clm %0d cmt %0d rel %0d ract %0d exp %0d qry %0d lst %0d",
             op_seen[F_RESERVE], op_seen[F_CLAIM], op_seen[F_COMMIT],
             op_seen[F_RELEASE], op_seen[F_RELEASE_ACTIVE], op_seen[F_EXPIRE],
             op_seen[F_QUERY], op_seen[F_LIST]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lsrt_pkg.sv
src/lsrt_cell.sv
src/lsrt_cfg.sv
src/lease_slot_reservation_table.sv
tb/lease_table_monitor.sv
tb/tb_lease_slot_reservation_table.sv
